@@ src/rapc_pkg.sv @@
// rapc_pkg: word types, outcome codes and fixed constants for the Rayleigh
// pixel correction pipeline. Depends on nothing; used by every other file.
`timescale 1ns / 1ps
package rapc_pkg;

  // Outcome codes of one result word
  typedef enum logic [1:0] {
    OUTC_NODATA = 2'd0,
    OUTC_PASS   = 2'd1,
    OUTC_CORR   = 2'd2,
    OUTC_CLAMP  = 2'd3
  } rapc_outcome_e;

  // Input word without the reflectance, whose width is a top-level parameter
  typedef struct packed {
    logic               pixel_valid;
    logic        [13:0] solar_zenith;
    logic        [13:0] view_zenith;
    logic signed [15:0] relative_azimuth;
  } rapc_pixel_t;

  // Result word without the corrected reflectance
  typedef struct packed {
    logic          result_valid;
    rapc_outcome_e outcome;
  } rapc_result_t;

  // Angle turns in 1/64 degree
  localparam logic [15:0] TWO_TURNS    = 16'd46080;
  localparam logic [14:0] FULL_TURN    = 15'd23040;
  localparam logic [14:0] HALF_TURN    = 15'd11520;
  localparam logic [14:0] QUARTER_TURN = 15'd5760;
  localparam logic [14:0] EIGHTH_TURN  = 15'd2880;

  // Radians per angle unit, Q40
  localparam logic [28:0] RAD_Q40 = 29'd299845282;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Trig unit latency in cycles
  localparam int unsigned TRIG_LAT = 14;

  // Reciprocal multipliers: exact floor(v/d) for v < 2^30 as (v*M) >> S
  localparam logic [31:0] MAG_90 = 32'(((64'd1 << 37) + 64'd89) / 64'd90);
  localparam logic [31:0] MAG_72 = 32'(((64'd1 << 37) + 64'd71) / 64'd72);
  localparam logic [31:0] MAG_56 = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
  localparam logic [31:0] MAG_30 = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
  localparam logic [31:0] MAG_12 = 32'(((64'd1 << 34) + 64'd11) / 64'd12);
  localparam logic [31:0] MAG_42 = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam logic [31:0] MAG_20 = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
  localparam logic [31:0] MAG_6  = 32'(((64'd1 << 33) + 64'd5) / 64'd6);
  localparam int unsigned SH_FIRST = 37;

  // Horner steps after the first term: cosine 56, 30, 12; sine 42, 20, 6
  localparam logic [31:0] COS_MAG [3] = '{MAG_56, MAG_30, MAG_12};
  localparam logic [31:0] SIN_MAG [3] = '{MAG_42, MAG_20, MAG_6};
  localparam int unsigned COS_SH  [3] = '{36, 35, 34};
  localparam int unsigned SIN_SH  [3] = '{36, 35, 33};

  // Phase function and low-cosine limit
  localparam logic [15:0] PHASE_K0 = 16'd30837;
  localparam logic [15:0] PHASE_K1 = 16'd29163;
  localparam logic [15:0] PHASE_DEN = 16'd40558;
  localparam logic signed [16:0] MU_MIN = 17'sd328;

  localparam logic [15:0] TAU_RESET = 16'd12128;

endpackage

@@ src/rapc_trig.sv @@
// rapc_trig: pipelined cosine and sine of one angle in Q1.15.
// Uses rapc_pkg for the turn constants and the reciprocal multipliers.
`timescale 1ns / 1ps
module rapc_trig (
  input  logic               clk_i,
  input  logic        [15:0] angle_i,
  output logic signed [16:0] cos_o,
  output logic signed [16:0] sin_o
);

  typedef struct packed {
    logic swap;
    logic cneg;
    logic sneg;
  } fold_t;

  // Reduce modulo one turn
  logic [15:0] amod;
  logic [14:0] mod_q;

  always_comb begin
    if (angle_i >= rapc_pkg::TWO_TURNS) begin
      amod = angle_i - rapc_pkg::TWO_TURNS;
    end else if (angle_i >= 16'(rapc_pkg::FULL_TURN)) begin
      amod = angle_i - 16'(rapc_pkg::FULL_TURN);
    end else begin
      amod = angle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_q <= amod[14:0];
  end

  // Fold onto the first octant
  logic [14:0] u1, u2, up;
  fold_t       fold;
  logic [11:0] up_q;
  fold_t       fl_q [12];

  always_comb begin
    fold = '0;
    u1 = mod_q;
    if (u1 > rapc_pkg::HALF_TURN) begin
      u1 = rapc_pkg::FULL_TURN - u1;
      fold.sneg = 1'b1;
    end
    u2 = u1;
    if (u2 > rapc_pkg::QUARTER_TURN) begin
      u2 = rapc_pkg::HALF_TURN - u2;
      fold.cneg = 1'b1;
    end
    fold.swap = (u2 > rapc_pkg::EIGHTH_TURN);
    up = fold.swap ? (rapc_pkg::QUARTER_TURN - u2) : u2;
  end

  always_ff @(posedge clk_i) begin
    up_q     <= up[11:0];
    fl_q[0]  <= fold;
    for (int i = 1; i < 12; i++) begin
      fl_q[i] <= fl_q[i-1];
    end
  end

  // Radians, square, first Horner term
  logic [40:0] xprod;
  logic [29:0] x_q, x5_q;
  logic [59:0] xx_q, xx_rnd;
  logic [29:0] x2;
  logic [61:0] qc0_p, qs0_p;

  assign xprod  = 41'(up_q) * 41'(rapc_pkg::RAD_Q40) + 41'd512;
  assign xx_rnd = xx_q + 60'(32'h2000_0000);
  assign x2     = xx_rnd[59:30];
  assign qc0_p  = 62'(x2) * 62'(rapc_pkg::MAG_90);
  assign qs0_p  = 62'(x2) * 62'(rapc_pkg::MAG_72);

  logic [29:0] x2_s [4];
  logic [29:0] xs_s [4];
  logic [29:0] qc_s [4];
  logic [29:0] qs_s [4];

  always_ff @(posedge clk_i) begin
    x_q     <= xprod[39:10];
    x5_q    <= x_q;
    xx_q    <= 60'(x_q) * 60'(x_q);
    x2_s[0] <= x2;
    xs_s[0] <= x5_q;
    qc_s[0] <= 30'(qc0_p >> rapc_pkg::SH_FIRST);
    qs_s[0] <= 30'(qs0_p >> rapc_pkg::SH_FIRST);
  end

  // Horner steps, two stages each: product, then reciprocal divide
  logic [60:0] pc_q [4];
  logic [60:0] ps_q [4];
  logic [29:0] x2_a [4];
  logic [29:0] xs_a [4];
  logic [30:0] c30_q, s30_q;

  for (genvar k = 0; k < 4; k++) begin : g_step
    logic [30:0] tc, ts;
    assign tc = rapc_pkg::Q30_ONE - 31'(qc_s[k]);
    assign ts = rapc_pkg::Q30_ONE - 31'(qs_s[k]);

    always_ff @(posedge clk_i) begin
      pc_q[k] <= 61'(x2_s[k]) * 61'(tc);
      if (k == 3) begin
        ps_q[k] <= 61'(xs_s[k]) * 61'(ts);
      end else begin
        ps_q[k] <= 61'(x2_s[k]) * 61'(ts);
      end
      x2_a[k] <= x2_s[k];
      xs_a[k] <= xs_s[k];
    end

    if (k < 3) begin : g_div
      logic [61:0] dc, ds;
      assign dc = 62'(pc_q[k][59:30]) * 62'(rapc_pkg::COS_MAG[k]);
      assign ds = 62'(ps_q[k][59:30]) * 62'(rapc_pkg::SIN_MAG[k]);
      always_ff @(posedge clk_i) begin
        qc_s[k+1] <= 30'(dc >> rapc_pkg::COS_SH[k]);
        qs_s[k+1] <= 30'(ds >> rapc_pkg::SIN_SH[k]);
        x2_s[k+1] <= x2_a[k];
        xs_s[k+1] <= xs_a[k];
      end
    end else begin : g_last
      // cosine: last term divides by two; sine: final multiply by x
      always_ff @(posedge clk_i) begin
        c30_q <= rapc_pkg::Q30_ONE - 31'(pc_q[k] >> 31);
        s30_q <= 31'(ps_q[k] >> 30);
      end
    end
  end

  // Round to Q15, undo the fold
  logic [31:0] c_rnd, s_rnd;
  logic [15:0] c15, s15, cv, sv;
  logic signed [16:0] cs_d, sn_d;

  assign c_rnd = 32'(c30_q) + 32'd16384;
  assign s_rnd = 32'(s30_q) + 32'd16384;
  assign c15   = c_rnd[30:15];
  assign s15   = s_rnd[30:15];
  assign cv    = fl_q[11].swap ? s15 : c15;
  assign sv    = fl_q[11].swap ? c15 : s15;
  assign cs_d  = fl_q[11].cneg ? -$signed({1'b0, cv}) : $signed({1'b0, cv});
  assign sn_d  = fl_q[11].sneg ? -$signed({1'b0, sv}) : $signed({1'b0, sv});

  always_ff @(posedge clk_i) begin
    cos_o <= cs_d;
    sin_o <= sn_d;
  end

endmodule

@@ src/rayleigh_analytic_pixel_correct.sv @@
// rayleigh_analytic_pixel_correct: single-scatter Rayleigh correction top.
// Depends on rapc_pkg and rapc_trig (three instances).
`timescale 1ns / 1ps
// One pixel word may be started in every cycle: busy_o never rises and the
// configuration channel is always ready. Each result appears for one cycle
// with strobe_o, after passing through the 14-stage trig units, the
// multiplier chain and the restoring division that yields one quotient bit per
// stage. The receiver cannot stall the block, so it must take every strobe.
module rayleigh_analytic_pixel_correct #(
  parameter int unsigned REFLECTANCE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  rapc_pkg::rapc_pixel_t       pixel_i,
  input  logic [REFLECTANCE_BITS-1:0] reflectance_i,
  output logic                        strobe_o,
  output rapc_pkg::rapc_result_t      result_o,
  output logic [REFLECTANCE_BITS-1:0] refl_corr_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [15:0]                 cfg_data_i
);

  localparam int unsigned R      = REFLECTANCE_BITS;
  localparam int unsigned WW     = R + 66;
  localparam int unsigned SIDE_N = R + 23;
  localparam int unsigned ST_P1  = rapc_pkg::TRIG_LAT + 1;
  localparam longint unsigned CLAMP_RAW = ((64'd1 << (R - 2)) + 64'd5000) / 64'd10000;
  localparam logic [R-1:0] CLAMP_VAL = R'((CLAMP_RAW == 0) ? 1 : CLAMP_RAW);

  typedef struct packed {
    logic         pv;
    logic         low;
    logic [R-1:0] refl;
  } side_t;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Optical depth register
  logic [15:0] tau_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tau_q <= rapc_pkg::TAU_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tau_q <= cfg_data_i;
    end
  end

  // Accept and side pipeline
  logic        acc;
  logic [15:0] raa;
  logic [SIDE_N:1] vld_q;
  side_t       side_q [1:SIDE_N];
  logic        low_d;

  assign acc = start_i && !busy_o;
  assign raa = pixel_i.relative_azimuth[15] ? (~pixel_i.relative_azimuth + 16'd1)
                                            : pixel_i.relative_azimuth;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SIDE_N-1:1], acc};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[1].pv   <= pixel_i.pixel_valid;
    side_q[1].low  <= 1'b0;
    side_q[1].refl <= reflectance_i;
    for (int k = 2; k <= SIDE_N; k++) begin
      if (k == ST_P1) begin
        side_q[k] <= '{pv: side_q[k-1].pv, low: low_d, refl: side_q[k-1].refl};
      end else begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Trig units
  logic signed [16:0] mus, sins, muv, sinv, cphi, sphi;

  rapc_trig u_trig_s (.clk_i, .angle_i({2'b00, pixel_i.solar_zenith}), .cos_o(mus),
                      .sin_o(sins));
  rapc_trig u_trig_v (.clk_i, .angle_i({2'b00, pixel_i.view_zenith}), .cos_o(muv),
                      .sin_o(sinv));
  rapc_trig u_trig_a (.clk_i, .angle_i(raa), .cos_o(cphi), .sin_o(sphi));

  // P1: sine and cosine products, low-cosine test
  logic signed [33:0] ss_q, mm_q, mm2_q, mm3_q, mm4_q;
  logic signed [16:0] cphi_q;
  assign low_d = (mus < rapc_pkg::MU_MIN) || (muv < rapc_pkg::MU_MIN) || (sphi == sphi + 17'sd1);

  // P2..P4: scattering cosine and its square
  logic signed [50:0] a_q;
  logic signed [51:0] cs;
  logic        [51:0] mag, mag_rnd;
  logic        [31:0] m_q;
  logic        [63:0] msq_q, msq_rnd;
  logic        [32:0] cs2;

  assign cs      = 52'(a_q) - (52'(mm2_q) <<< 15);
  assign mag     = cs[51] ? 52'(-cs) : 52'(cs);
  assign mag_rnd = mag + 52'd16384;
  assign msq_rnd = msq_q + 64'h2000_0000;
  assign cs2     = msq_rnd[62:30];

  // P5..P7: numerator and denominator
  logic [47:0] k1cs_q;
  logic [46:0] den_q, den6_q, den7_q;
  logic [48:0] sum_q;
  logic [64:0] num_q;

  always_ff @(posedge clk_i) begin
    ss_q   <= 34'(sins) * 34'(sinv);
    mm_q   <= 34'(mus) * 34'(muv);
    cphi_q <= cphi;
    a_q    <= 51'(ss_q) * 51'(cphi_q);
    mm2_q  <= mm_q;
    mm3_q  <= mm2_q;
    m_q    <= mag_rnd[46:15];
    mm4_q  <= mm3_q;
    msq_q  <= 64'(m_q) * 64'(m_q);
    k1cs_q <= 48'(rapc_pkg::PHASE_K1) * 48'(cs2);
    den_q  <= 47'(rapc_pkg::PHASE_DEN) * 47'(mm4_q[30:0]);
    sum_q  <= (49'(rapc_pkg::PHASE_K0) << 30) + 49'(k1cs_q);
    den6_q <= den_q;
    num_q  <= 65'(tau_q) * 65'(sum_q);
    den7_q <= den6_q;
  end

  // Restoring division, one quotient bit per stage, saturating past R+1 bits
  logic [WW-1:0] dr_q   [R+2];
  logic [R:0]    dq_q   [R+2];
  logic [46:0]   dd_q   [R+2];
  logic          dsat_q [R+2];
  logic [WW-1:0] n_full, d_top;

  assign n_full = WW'(num_q) << (R - 1);
  assign d_top  = WW'(den7_q) << (R + 19);

  always_ff @(posedge clk_i) begin
    dr_q[0]   <= n_full;
    dq_q[0]   <= '0;
    dd_q[0]   <= den7_q;
    dsat_q[0] <= (n_full >= d_top);
  end

  for (genvar j = 0; j <= R; j++) begin : g_div
    localparam int unsigned BI = R - j;
    logic [WW-1:0] sub;
    assign sub = WW'(dd_q[j]) << (BI + 18);
    always_ff @(posedge clk_i) begin
      dd_q[j+1]   <= dd_q[j];
      dsat_q[j+1] <= dsat_q[j];
      if (dr_q[j] >= sub) begin
        dr_q[j+1]     <= dr_q[j] - sub;
        dq_q[j+1]     <= dq_q[j] | ((R+1)'(1) << BI);
      end else begin
        dr_q[j+1]     <= dr_q[j];
        dq_q[j+1]     <= dq_q[j];
      end
    end
  end

  // Final rounding, clamp and result word
  side_t         fs;
  logic [R+1:0]  rho_sum;
  logic [R:0]    rho;
  logic          clamp;

  assign fs      = side_q[SIDE_N];
  assign rho_sum = (R+2)'(dq_q[R+1]) + (R+2)'(1);
  assign rho     = rho_sum[R+1:1];
  assign clamp   = dsat_q[R+1] || (rho > (R+1)'(fs.refl));

  logic                  strobe_q;
  rapc_pkg::rapc_result_t res_q;
  logic [R-1:0]          refl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= vld_q[SIDE_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!fs.pv) begin
      res_q  <= '{result_valid: 1'b0, outcome: rapc_pkg::OUTC_NODATA};
      refl_q <= '0;
    end else if (fs.low) begin
      res_q  <= '{result_valid: 1'b1, outcome: rapc_pkg::OUTC_PASS};
      refl_q <= fs.refl;
    end else if (clamp) begin
      res_q  <= '{result_valid: 1'b1, outcome: rapc_pkg::OUTC_CLAMP};
      refl_q <= CLAMP_VAL;
    end else begin
      res_q  <= '{result_valid: 1'b1, outcome: rapc_pkg::OUTC_CORR};
      refl_q <= fs.refl - rho[R-1:0];
    end
  end

  assign strobe_o    = strobe_q;
  assign result_o    = res_q;
  assign refl_corr_o = refl_q;

endmodule

@@ src/rapc_checker.sv @@
// rapc_checker: port-level assertions for the Rayleigh pixel correction top,
// bound to it below. Depends on rapc_pkg.
`timescale 1ns / 1ps
module rapc_checker #(
  parameter int unsigned REFLECTANCE_BITS = 16
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        strobe_o,
  input rapc_pkg::rapc_result_t      result_o,
  input logic [REFLECTANCE_BITS-1:0] refl_corr_o
);

  localparam int unsigned LAT = REFLECTANCE_BITS + 24;

  // Every started word comes out after the fixed latency
  a_lat_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT strobe_o)
    else $error("result missing at fixed latency");

  // No result word without a start
  a_lat_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##LAT !strobe_o)
    else $error("result without a started word");

  // No-data words carry zero and the no-data code
  a_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !result_o.result_valid) |->
      (refl_corr_o == '0 && result_o.outcome == rapc_pkg::OUTC_NODATA))
    else $error("bad no-data result");

  // Valid words never carry the no-data code; a clamp is never zero
  a_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && result_o.result_valid) |->
      (result_o.outcome != rapc_pkg::OUTC_NODATA &&
       (result_o.outcome != rapc_pkg::OUTC_CLAMP || refl_corr_o != '0)))
    else $error("bad valid result");

endmodule

bind rayleigh_analytic_pixel_correct rapc_checker #(
  .REFLECTANCE_BITS(REFLECTANCE_BITS)
) u_rapc_checker (
  .clk_i,
  .rst_ni,
  .start_i,
  .busy_o,
  .strobe_o,
  .result_o,
  .refl_corr_o
);
